@@ rtl/float32_square_root_assert.svh @@
// Assertion macros shared by the float32 square root RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FLOAT32_SQUARE_ROOT_ASSERT_SVH
`define FLOAT32_SQUARE_ROOT_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define FSR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on the rising clock edge, reset cycles included.
`define FSR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/fsr_pkg.sv @@
// Types, constants and helpers for the float32 square root pipeline.
// Depends on nothing; used by every RTL module of the block.
package fsr_pkg;

    localparam int unsigned NumCells = 25;   // 24 significand bits plus round bit
    localparam int unsigned RemW     = 28;   // partial remainder and root image
    localparam int unsigned RootW    = 25;

    localparam logic [31:0] ExpMask   = 32'h7f80_0000;
    localparam logic [31:0] FracMask  = 32'h007f_ffff;
    localparam logic [31:0] QuietBit  = 32'h0040_0000;
    localparam logic [31:0] CanonNan  = 32'h7fc0_0000;
    localparam logic [31:0] HalfExp   = 32'h3f00_0000;
    localparam logic [31:0] ExpOffset = 32'h4000_0000;  // 128 << 23

    typedef struct packed {
        logic              valid;
        logic              special;
        logic [31:0]       spec_word;
        logic [7:0]        k_half;
        logic [RemW-1:0]   rem;
        logic [RemW-1:0]   s;
        logic [RootW-1:0]  q;
    } t_cell_data;

    // Left shift that brings the leading one of a subnormal fraction to bit 23.
    function automatic logic [4:0] sub_shift(input logic [22:0] frac);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

endpackage

@@ rtl/float32_square_root.sv @@
// Top level of the float32 square root: front end, cell chain, rounding.
// Depends on fsr_pkg, fsr_front, fsr_cell, fsr_round and the assert header.
//
// Single-precision square root, round to nearest even. One request is taken
// per cycle while the pipe advances. The pipe has two front-end stages (take
// in the operand and its subnormal shift; classify and normalize), a chain of
// 25 restoring recurrence cells that each settle one root bit, and one
// rounding stage whose register is the output register. The whole pipe
// advances together; while a result waits untaken at the output, the pipe
// holds and tready drops. Zero returns itself, +inf gives +inf, NaN comes
// back quieted, and -inf or any negative nonzero gives 0x7FC00000.
`include "float32_square_root_assert.svh"

module float32_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] operand_bits
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] root_bits
);

    logic en;
    fsr_pkg::t_cell_data chain [fsr_pkg::NumCells+1];

    // Advance the pipe unless a finished result is stuck at the output.
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    fsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata),
        .o_data  (chain[0])
    );

    for (genvar g = 0; g < fsr_pkg::NumCells; g++) begin : g_cell
        fsr_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_data  (chain[g]),
            .o_data  (chain[g+1])
        );
    end

    fsr_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_data  (chain[fsr_pkg::NumCells]),
        .o_valid (o_m_axis_tvalid),
        .o_word  (o_m_axis_tdata)
    );

    `FSR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    `FSR_ASSERT(a_stall_holds, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `FSR_ASSERT(a_neg_only_nan_or_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[31] |->
        o_m_axis_tdata[30:23] == 8'hff || o_m_axis_tdata[30:0] == 31'd0)

endmodule

@@ rtl/fsr_front.sv @@
// Front end: classify the operand, normalize subnormals, seed the recurrence.
// Depends on fsr_pkg.
module fsr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_x,
    output fsr_pkg::t_cell_data  o_data
);

    logic        r_valid1, n_valid1;
    logic [31:0] r_x;
    logic [4:0]  r_shift;
    fsr_pkg::t_cell_data r_data, n_data;

    logic [4:0] n_shift;
    logic       is_max_exp, is_zero, is_sub;
    logic [31:0] spec_word;
    logic        special;
    logic [23:0] mant24;
    logic [8:0]  k;

    assign n_valid1 = i_valid;
    assign n_shift  = fsr_pkg::sub_shift(i_x[22:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= n_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= i_x;
            r_shift <= n_shift;
            r_data.special   <= n_data.special;
            r_data.spec_word <= n_data.spec_word;
            r_data.k_half    <= n_data.k_half;
            r_data.rem       <= n_data.rem;
            r_data.s         <= n_data.s;
            r_data.q         <= n_data.q;
        end
        if (!i_rst_n)  r_data.valid <= 1'b0;
        else if (i_en) r_data.valid <= n_data.valid;
    end

    always_comb begin
        is_max_exp = (r_x & fsr_pkg::ExpMask) == fsr_pkg::ExpMask;
        is_zero    = r_x[30:0] == 31'd0;
        is_sub     = r_x[30:23] == 8'd0;
        special    = 1'b1;
        spec_word  = fsr_pkg::CanonNan;
        if (is_max_exp) begin
            if ((r_x & fsr_pkg::FracMask) != 32'd0) spec_word = r_x | fsr_pkg::QuietBit;
            else if (!r_x[31])                      spec_word = r_x;
        end else if (is_zero) begin
            spec_word = r_x;
        end else if (!r_x[31]) begin
            special = 1'b0;
        end
        if (is_sub) begin
            mant24 = {1'b0, r_x[22:0]} << r_shift;
            k      = 9'd130 - {4'd0, r_shift};
        end else begin
            mant24 = {1'b1, r_x[22:0]};
            k      = {1'b0, r_x[30:23]} + 9'd129;
        end
        n_data.valid     = r_valid1;
        n_data.special   = special;
        n_data.spec_word = spec_word;
        n_data.k_half    = k[8:1];
        n_data.rem       = {4'd0, mant24} << (k[0] ? 2 : 1);
        n_data.s         = '0;
        n_data.q         = '0;
    end

    assign o_data = r_data;

endmodule

@@ rtl/fsr_cell.sv @@
// One restoring square root step: decide one root bit, update remainder.
// Depends on fsr_pkg.
module fsr_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fsr_pkg::t_cell_data  i_data,
    output fsr_pkg::t_cell_data  o_data
);

    localparam logic [fsr_pkg::RemW-1:0] Bit =
        fsr_pkg::RemW'(1) << (fsr_pkg::NumCells - 1 - STEP);

    fsr_pkg::t_cell_data r_data, n_data;
    logic [fsr_pkg::RemW-1:0] t;

    always_comb begin
        n_data = i_data;
        t      = i_data.s + Bit;
        if (t <= i_data.rem) begin
            n_data.s   = t + Bit;
            n_data.rem = i_data.rem - t;
            n_data.q   = i_data.q | Bit[fsr_pkg::RootW-1:0];
        end
        n_data.rem = n_data.rem << 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data.special   <= n_data.special;
            r_data.spec_word <= n_data.spec_word;
            r_data.k_half    <= n_data.k_half;
            r_data.rem       <= n_data.rem;
            r_data.s         <= n_data.s;
            r_data.q         <= n_data.q;
        end
        if (!i_rst_n)  r_data.valid <= 1'b0;
        else if (i_en) r_data.valid <= n_data.valid;
    end

    assign o_data = r_data;

endmodule

@@ rtl/fsr_round.sv @@
// Round to nearest even, assemble the result word, hold the output register.
// Depends on fsr_pkg.
module fsr_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fsr_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    output logic [31:0]          o_word
);

    logic        r_valid;
    logic [31:0] r_word, n_word;
    // One bit wider than the root so a round-up to 2.0 carries into the exponent.
    logic [fsr_pkg::RootW:0] q_rnd;

    always_comb begin
        q_rnd  = {1'b0, i_data.q} + {{fsr_pkg::RootW{1'b0}},
                                     (i_data.rem != '0) & i_data.q[0]};
        n_word = {7'd0, q_rnd[fsr_pkg::RootW:1]} + fsr_pkg::HalfExp
               + {1'b0, i_data.k_half, 23'd0} - fsr_pkg::ExpOffset;
        if (i_data.special) n_word = i_data.spec_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_valid <= 1'b0;
        else if (i_en) r_valid <= i_data.valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
